/* design/tdp_pkg.sv */
// ----------------------------------------------------------------------------
// tdp_pkg: shared constants and types for the trial-division prime test
// Widths of the candidate, trial divisor and running square, plus the
// command and status words passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tdp_pkg;

	// candidate width
	localparam int VALUE_BITS = 31;
	// trial divisor never exceeds about sqrt(2^VALUE_BITS) + 2
	localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 1;
	// running square of the divisor
	localparam int SQ_BITS    = 2 * DIV_BITS;
	// bit index into the candidate for the remainder unit
	localparam int CNT_BITS   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture candidate, divisor = 3, square = 9
		logic div_start;  // clear remainder, point at candidate MSB
		logic div_step;   // one restoring remainder step
		logic advance;    // divisor += 2, square updated
	} tdp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic trivial;        // below two or even
		logic trivial_prime;  // candidate equals two
		logic over_bound;     // divisor squared exceeds candidate
		logic div_last;       // remainder step on bit 0
		logic rem_zero;       // remainder is zero
	} tdp_status_t;

endpackage : tdp_pkg

`default_nettype wire

/* design/trial_division_prime_test.sv */
// ----------------------------------------------------------------------------
// trial_division_prime_test: primality test by odd trial division
// Top level joining the sequencer and the divisor datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A word is accepted on a rising edge with start high and busy low;
//   candidate is sampled then. busy stays high while the test runs.
//   The answer appears on prime with done high for exactly one cycle;
//   the receiver cannot stall, so it must take the word in that cycle.
// Sequence after the accepting edge:
//   Zero, one and even candidates: the screen in S_CHECK ends the test.
//   Odd candidates: each trial divisor takes a bound check in S_CHECK,
//   VALUE_BITS bit-serial remainder steps in S_DIV on the shared
//   restoring unit, and a remainder test in S_TEST; a prime ends at a
//   bound check that is passed, a composite at a zero remainder.
//   With VALUE_BITS = 31 a prime near 2^31 tries about 23000 divisors;
//   a composite stops at its least odd factor.
// Throughput: one word at a time; busy drops with done, so the next
//   start is already taken at the edge that ends the done cycle.
// Reset:
//   arst_n low returns the sequencer to idle with done low; any test in
//   progress is dropped and no result is produced for it.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [tdp_pkg::VALUE_BITS-1:0] candidate,
	output logic                                busy,
	output logic                                done,
	output logic                                prime
);
	import tdp_pkg::*;

	tdp_cmd_t    cmd;
	tdp_status_t status;

	// sequencer
	tdp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.prime  (prime)
	);

	// divisor, square and remainder unit
	tdp_datapath u_datapath (
		.clk       (clk),
		.candidate (candidate),
		.cmd       (cmd),
		.status    (status)
	);

endmodule : trial_division_prime_test

`default_nettype wire

/* design/tdp_datapath.sv */
// ----------------------------------------------------------------------------
// tdp_datapath: candidate, divisor, square and remainder unit
// Holds the word under test and the trial divisor; a bit-serial restoring
// remainder unit takes one candidate bit per cycle while div_step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_datapath (
	input  wire logic                           clk,
	input  wire logic [tdp_pkg::VALUE_BITS-1:0] candidate,
	input  wire tdp_pkg::tdp_cmd_t              cmd,
	output tdp_pkg::tdp_status_t                status
);
	import tdp_pkg::*;

	logic [VALUE_BITS-1:0] value_q;
	logic [DIV_BITS-1:0]   divisor_q;
	logic [SQ_BITS-1:0]    square_q;
	logic [DIV_BITS-1:0]   rem_q;
	logic [CNT_BITS-1:0]   idx_q;

	logic [DIV_BITS:0]     rem_shift;
	logic [DIV_BITS:0]     rem_sub;
	logic [DIV_BITS-1:0]   rem_next;

	// one restoring step: shift in next candidate bit, subtract if it fits
	always_comb begin
		rem_shift = {rem_q, value_q[idx_q]};
		rem_sub   = rem_shift - {1'b0, divisor_q};
		if (rem_shift >= {1'b0, divisor_q}) begin
			rem_next = rem_sub[DIV_BITS-1:0];
		end else begin
			rem_next = rem_shift[DIV_BITS-1:0];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q   <= candidate;
			divisor_q <= DIV_BITS'(3);
			square_q  <= SQ_BITS'(9);
		end else if (cmd.advance) begin
			// (d+2)^2 = d^2 + 4d + 4
			divisor_q <= divisor_q + DIV_BITS'(2);
			square_q  <= square_q + SQ_BITS'({divisor_q, 2'b00}) + SQ_BITS'(4);
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			idx_q <= CNT_BITS'(VALUE_BITS - 1);
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			idx_q <= idx_q - CNT_BITS'(1);
		end
	end

	// status back to the controller
	always_comb begin
		status.trivial       = (value_q < VALUE_BITS'(2)) || !value_q[0];
		status.trivial_prime = (value_q == VALUE_BITS'(2));
		status.over_bound    = (square_q > SQ_BITS'(value_q));
		status.div_last      = (idx_q == '0);
		status.rem_zero      = (rem_q == '0);
	end

endmodule : tdp_datapath

`default_nettype wire

/* design/tdp_ctrl.sv */
// ----------------------------------------------------------------------------
// tdp_ctrl: sequencer for the prime test
// Screens trivial cases, then loops bound check, remainder and advance
// until a divisor hits or the bound is passed; drives the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module tdp_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire tdp_pkg::tdp_status_t status,
	output tdp_pkg::tdp_cmd_t         cmd,
	output logic                      busy,
	output logic                      done,
	output logic                      prime
);
	import tdp_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;
	localparam logic [1:0] S_TEST  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       done_q;
	logic       done_d;
	logic       prime_q;
	logic       prime_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		prime_d = prime_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.trivial) begin
					done_d  = 1'b1;
					prime_d = status.trivial_prime;
					state_d = S_IDLE;
				end else if (status.over_bound) begin
					done_d  = 1'b1;
					prime_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (status.rem_zero) begin
					done_d  = 1'b1;
					prime_d = 1'b0;
					state_d = S_IDLE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_CHECK;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			prime_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			prime_q <= prime_d;
		end
	end

	assign busy  = (state_q != S_IDLE);
	assign done  = done_q;
	assign prime = prime_q;

endmodule : tdp_ctrl

`default_nettype wire
